### rtl/fvap_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and tables of the four voice adpcm player
package fvap_pkg;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CMD    = 2'd1,
        OP_TICK   = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_OUTPUT_RATE = 2'd0,
        CFG_DECODE_RATE = 2'd1,
        CFG_ROM_LENGTH  = 2'd2
    } cfg_idx_t;

    localparam int STEP_LEVELS = 49;
    localparam logic signed [15:0] MIX_LIMIT = 16'sh7ff0;

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_HDR_RD  = 14'b00000000000010,
        ST_HDR_CAP = 14'b00000000000100,
        ST_LOOP    = 14'b00000000001000,
        ST_DCHK    = 14'b00000000010000,
        ST_DNIB    = 14'b00000000100000,
        ST_DVAL    = 14'b00000001000000,
        ST_DSCL    = 14'b00000010000000,
        ST_SUM     = 14'b00000100000000,
        ST_IM1     = 14'b00001000000000,
        ST_IM2     = 14'b00010000000000,
        ST_DIV     = 14'b00100000000000,
        ST_DONE    = 14'b01000000000000,
        ST_OUT     = 14'b10000000000000
    } state_t;

    function automatic logic [10:0] step_base(input logic [5:0] idx);
        logic [10:0] r;
        case (idx)
            6'd0: r = 11'd16;    6'd1: r = 11'd17;    6'd2: r = 11'd19;
            6'd3: r = 11'd21;    6'd4: r = 11'd23;    6'd5: r = 11'd25;
            6'd6: r = 11'd28;    6'd7: r = 11'd31;    6'd8: r = 11'd34;
            6'd9: r = 11'd37;    6'd10: r = 11'd41;   6'd11: r = 11'd45;
            6'd12: r = 11'd50;   6'd13: r = 11'd55;   6'd14: r = 11'd60;
            6'd15: r = 11'd66;   6'd16: r = 11'd73;   6'd17: r = 11'd80;
            6'd18: r = 11'd88;   6'd19: r = 11'd97;   6'd20: r = 11'd107;
            6'd21: r = 11'd118;  6'd22: r = 11'd130;  6'd23: r = 11'd143;
            6'd24: r = 11'd157;  6'd25: r = 11'd173;  6'd26: r = 11'd190;
            6'd27: r = 11'd209;  6'd28: r = 11'd230;  6'd29: r = 11'd253;
            6'd30: r = 11'd279;  6'd31: r = 11'd307;  6'd32: r = 11'd337;
            6'd33: r = 11'd371;  6'd34: r = 11'd408;  6'd35: r = 11'd449;
            6'd36: r = 11'd494;  6'd37: r = 11'd544;  6'd38: r = 11'd598;
            6'd39: r = 11'd658;  6'd40: r = 11'd724;  6'd41: r = 11'd796;
            6'd42: r = 11'd876;  6'd43: r = 11'd963;  6'd44: r = 11'd1060;
            6'd45: r = 11'd1166; 6'd46: r = 11'd1282; 6'd47: r = 11'd1411;
            6'd48: r = 11'd1552;
            default: r = 11'd1552;
        endcase
        return r;
    endfunction

    function automatic logic signed [6:0] step_move(input logic [2:0] n);
        logic signed [6:0] r;
        case (n)
            3'd4: r = 7'sd2;
            3'd5: r = 7'sd4;
            3'd6: r = 7'sd6;
            3'd7: r = 7'sd8;
            default: r = -7'sd1;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] vol_level(input logic [3:0] i);
        logic [7:0] r;
        case (i)
            4'd0: r = 8'd80;  4'd1: r = 8'd56;  4'd2: r = 8'd40;  4'd3: r = 8'd28;
            4'd4: r = 8'd20;  4'd5: r = 8'd14;  4'd6: r = 8'd10;  4'd7: r = 8'd7;
            4'd8: r = 8'd5;   4'd9: r = 8'd3;   4'd10: r = 8'd2;  4'd11: r = 8'd1;
            4'd12: r = 8'd1;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/fvap_if.sv
`timescale 1ns / 1ps
// request, result and configuration channels of the four voice adpcm player
interface fvap_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [17:0] rom_address;
    logic [7:0]  rom_byte;
    logic [7:0]  command_byte;
    modport source (output valid, operation, rom_address, rom_byte, command_byte, input ready);
    modport sink (input valid, operation, rom_address, rom_byte, command_byte, output ready);
endinterface

interface fvap_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic [7:0]         status;
    modport source (output valid, sample, status, input ready);
    modport sink (input valid, sample, status, output ready);
endinterface

interface fvap_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [18:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

### rtl/fvap_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read
module fvap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/four_voice_adpcm_player.sv
`timescale 1ns / 1ps
// four voice adpcm player top level
// cmd takes one request at a time: load a rom byte, write a command byte,
// an output tick or a status read. cfg writes output_rate, decode_rate and
// rom_length and is always ready; write it only while the block is idle.
// result carries sample and status for ticks (output_rate nonzero) and
// status reads; loads and commands give no result.
// a voice start reads six header bytes from rom. a tick runs decode passes
// while they are due and then interpolates; in a pass an idle or skipped
// voice is passed over, and a playing voice decodes through one shared
// multiplier and one rom read port. the interpolation divides with a
// 32 step restoring divider.
// reset clears voices, mix, accumulator and flags; rom contents survive.
// when result stalls the finished result waits in its output register
// and the next request is still taken; a later result waits for it.
module four_voice_adpcm_player #(
    parameter int ROM_BYTES = 262144
) (
    input logic clk,
    input logic rst_n,
    fvap_in_if.sink    cmd,
    fvap_out_if.source result,
    fvap_cfg_if.sink   cfg
);
    import fvap_pkg::*;

    localparam int AW = $clog2(ROM_BYTES);
    localparam logic [24:0] ROM_TOP = 25'(ROM_BYTES);

    state_t state_reg, state_next;

    logic [15:0] out_rate_reg, dec_rate_reg;
    logic [18:0] rom_len_reg;

    logic [24:0]        pos_reg [4];
    logic [24:0]        end_reg [4];
    logic signed [15:0] val_reg [4];
    logic signed [6:0]  step_reg [4];
    logic [7:0]         vol_reg [4];
    logic signed [23:0] scl_reg [4];
    logic [3:0]         flags_reg;
    logic [7:0]         pend_reg;
    logic signed [15:0] cur_reg, prev_reg;
    logic [17:0]        acc_reg;

    logic [1:0]  vidx_reg;
    logic [7:0]  sel_reg;
    logic [9:0]  hbase_reg;
    logic [2:0]  hcnt_reg;
    logic [47:0] hbuf_reg;
    logic        oob_reg;
    logic [3:0]  nib_reg;
    logic [5:0]  stc_reg;
    logic signed [33:0] prod_reg;
    logic        neg_reg;
    logic [31:0] dvd_reg;
    logic [16:0] rem_reg;
    logic [4:0]  dcnt_reg;
    logic signed [15:0] res_sample_reg;
    logic        out_valid_reg;
    logic signed [15:0] out_sample_reg;
    logic [7:0]  out_status_reg;

    // shared multiplier
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] mul_p;
    assign mul_p = mul_a * mul_b;

    logic        ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]  ram_rdata;
    logic [31:0] ld_addr32;
    logic [24:0] nib_addr;
    logic [31:0] rd_addr32;

    fvap_ram #(.WIDTH(8), .DEPTH(ROM_BYTES)) u_rom (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (cmd.rom_byte),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic cmd_fire;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire = cmd.valid && cmd.ready;
    assign cfg.ready = 1'b1;

    assign ld_addr32 = 32'(cmd.rom_address);
    assign ram_waddr = ld_addr32[AW-1:0];
    assign ram_we = cmd_fire && (cmd.operation == OP_LOAD)
                    && ({7'd0, cmd.rom_address} < ROM_TOP);

    assign nib_addr = {1'b0, pos_reg[vidx_reg][24:1]};

    always_comb
    begin
        if (state_reg == ST_HDR_RD)
        begin
            rd_addr32 = 32'(hbase_reg) + 32'(hcnt_reg);
        end
        else
        begin
            rd_addr32 = 32'(nib_addr);
        end
    end
    assign ram_raddr = rd_addr32[AW-1:0];

    // voice select of a start command
    logic       sel_any;
    logic [1:0] sel_voice;
    always_comb
    begin
        sel_any = |cmd.command_byte[7:4];
        if (cmd.command_byte[4])
        begin
            sel_voice = 2'd0;
        end
        else if (cmd.command_byte[5])
        begin
            sel_voice = 2'd1;
        end
        else if (cmd.command_byte[6])
        begin
            sel_voice = 2'd2;
        end
        else
        begin
            sel_voice = 2'd3;
        end
    end

    logic [9:0]  hbase;
    logic        hdr_ok;
    assign hbase = {pend_reg[6:0], 3'd0};
    assign hdr_ok = ({9'd0, hbase} + 19'd6) <= rom_len_reg;

    // decode, mix and interpolation datapath
    logic [3:0]         nib;
    logic [5:0]         stc;
    logic signed [22:0] v63;
    logic signed [22:0] v63_adj;
    logic signed [15:0] vq;
    logic signed [15:0] mag;
    logic signed [15:0] delta;
    logic signed [25:0] mix_sum;
    logic signed [23:0] mix_q;
    logic signed [15:0] mix_clamped;
    logic [16:0]        rem_sh;
    logic signed [34:0] num;
    logic [34:0]        num_abs;
    logic [15:0]        rate_gap;

    always_comb
    begin
        if (oob_reg)
        begin
            nib = 4'd0;
        end
        else if (pos_reg[vidx_reg][0])
        begin
            nib = ram_rdata[3:0];
        end
        else
        begin
            nib = ram_rdata[7:4];
        end
        if (step_reg[vidx_reg] < 0)
        begin
            stc = 6'd0;
        end
        else if (step_reg[vidx_reg] > 7'sd48)
        begin
            stc = 6'd48;
        end
        else
        begin
            stc = step_reg[vidx_reg][5:0];
        end
        v63 = (23'(val_reg[vidx_reg]) <<< 6) - 23'(val_reg[vidx_reg]);
        v63_adj = (v63 < 0) ? v63 + 23'sd63 : v63;
        vq = 16'(v63_adj >>> 6);
        mag = {4'd0, prod_reg[15:4]};
        delta = nib_reg[3] ? -mag : mag;
        mix_sum = 26'(scl_reg[0]) + 26'(scl_reg[1]) + 26'(scl_reg[2]) + 26'(scl_reg[3]);
        mix_q = 24'(mix_sum >>> 2);
        if (mix_q > 24'(MIX_LIMIT))
        begin
            mix_clamped = MIX_LIMIT;
        end
        else if (mix_q < -24'(MIX_LIMIT))
        begin
            mix_clamped = -MIX_LIMIT;
        end
        else
        begin
            mix_clamped = mix_q[15:0];
        end
        rate_gap = out_rate_reg - acc_reg[15:0];
        num = 35'(prod_reg) + 35'(mul_p);
        num_abs = (num < 0) ? 35'(-num) : 35'(num);
        rem_sh = {rem_reg[15:0], dvd_reg[31]};
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_DNIB:
            begin
                mul_a = 17'(step_base(stc));
                mul_b = 17'({nib[2:0], 1'b1});
            end
            ST_DSCL:
            begin
                mul_a = 17'(val_reg[vidx_reg]);
                mul_b = 17'(vol_reg[vidx_reg]);
            end
            ST_IM1:
            begin
                mul_a = 17'(prev_reg);
                mul_b = 17'(rate_gap);
            end
            ST_IM2:
            begin
                mul_a = 17'(cur_reg);
                mul_b = 17'(acc_reg[15:0]);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (cmd.operation)
                        OP_CMD:
                        begin
                            if ((pend_reg != 8'd0) && sel_any && hdr_ok)
                            begin
                                state_next = ST_HDR_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (out_rate_reg != 16'd0)
                            begin
                                state_next = (acc_reg >= 18'(out_rate_reg)) ? ST_LOOP : ST_IM1;
                            end
                        end
                        OP_STATUS: state_next = ST_OUT;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_HDR_RD: state_next = ST_HDR_CAP;
            ST_HDR_CAP: state_next = (hcnt_reg == 3'd5) ? ST_IDLE : ST_HDR_RD;
            ST_LOOP: state_next = (acc_reg >= 18'(out_rate_reg)) ? ST_DCHK : ST_SUM;
            ST_DCHK:
            begin
                if ((pos_reg[vidx_reg] >= end_reg[vidx_reg]) || (nib_addr >= 25'(rom_len_reg)))
                begin
                    state_next = (vidx_reg == 2'd3) ? ST_LOOP : ST_DCHK;
                end
                else
                begin
                    state_next = ST_DNIB;
                end
            end
            ST_DNIB: state_next = ST_DVAL;
            ST_DVAL: state_next = ST_DSCL;
            ST_DSCL: state_next = (vidx_reg == 2'd3) ? ST_LOOP : ST_DCHK;
            ST_SUM: state_next = ST_IM1;
            ST_IM1: state_next = ST_IM2;
            ST_IM2: state_next = ST_DIV;
            ST_DIV: state_next = (dcnt_reg == 5'd31) ? ST_DONE : ST_DIV;
            ST_DONE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            out_rate_reg <= '0;
            dec_rate_reg <= '0;
            rom_len_reg <= '0;
            for (int i = 0; i < 4; i++)
            begin
                pos_reg[i] <= '0;
                end_reg[i] <= '0;
                val_reg[i] <= '0;
                step_reg[i] <= '0;
                vol_reg[i] <= '0;
                scl_reg[i] <= '0;
            end
            flags_reg <= '0;
            pend_reg <= '0;
            cur_reg <= '0;
            prev_reg <= '0;
            acc_reg <= '0;
            vidx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    CFG_OUTPUT_RATE: out_rate_reg <= cfg.data[15:0];
                    CFG_DECODE_RATE: dec_rate_reg <= cfg.data[15:0];
                    CFG_ROM_LENGTH: rom_len_reg <= cfg.data;
                    default: rom_len_reg <= rom_len_reg;
                endcase
            end
            if ((state_reg == ST_OUT) && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_fire && (cmd.operation == OP_CMD))
                    begin
                        if (pend_reg != 8'd0)
                        begin
                            pend_reg <= '0;
                            sel_reg <= cmd.command_byte;
                            vidx_reg <= sel_voice;
                            hbase_reg <= hbase;
                            hcnt_reg <= '0;
                        end
                        else if (cmd.command_byte[7])
                        begin
                            pend_reg <= cmd.command_byte;
                        end
                        else
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                if (cmd.command_byte[3 + i])
                                begin
                                    end_reg[i] <= '0;
                                    flags_reg[i] <= 1'b0;
                                end
                            end
                        end
                    end
                    if (cmd_fire && (cmd.operation == OP_TICK) && (out_rate_reg != 16'd0)
                        && (acc_reg >= 18'(out_rate_reg)))
                    begin
                        prev_reg <= cur_reg;
                    end
                    if (cmd_fire && (cmd.operation == OP_STATUS))
                    begin
                        res_sample_reg <= '0;
                    end
                end
                ST_HDR_CAP:
                begin
                    hbuf_reg <= {hbuf_reg[39:0], ram_rdata};
                    hcnt_reg <= hcnt_reg + 3'd1;
                    if (hcnt_reg == 3'd5)
                    begin
                        pos_reg[vidx_reg] <= {hbuf_reg[39:16], 1'b0};
                        end_reg[vidx_reg] <= {hbuf_reg[15:0], ram_rdata, 1'b0};
                        val_reg[vidx_reg] <= '0;
                        step_reg[vidx_reg] <= '0;
                        vol_reg[vidx_reg] <= vol_level(sel_reg[3:0]);
                        scl_reg[vidx_reg] <= '0;
                        flags_reg[vidx_reg] <= 1'b1;
                    end
                end
                ST_LOOP:
                begin
                    vidx_reg <= '0;
                end
                ST_DCHK:
                begin
                    oob_reg <= nib_addr >= ROM_TOP;
                    if (pos_reg[vidx_reg] >= end_reg[vidx_reg])
                    begin
                        val_reg[vidx_reg] <= '0;
                        flags_reg[vidx_reg] <= 1'b0;
                        vidx_reg <= vidx_reg + 2'd1;
                    end
                    else if (nib_addr >= 25'(rom_len_reg))
                    begin
                        pos_reg[vidx_reg] <= '0;
                        vidx_reg <= vidx_reg + 2'd1;
                    end
                    if (((pos_reg[vidx_reg] >= end_reg[vidx_reg])
                        || (nib_addr >= 25'(rom_len_reg))) && (vidx_reg == 2'd3))
                    begin
                        acc_reg <= acc_reg - 18'(out_rate_reg);
                    end
                end
                ST_DNIB:
                begin
                    nib_reg <= nib;
                    stc_reg <= stc;
                    pos_reg[vidx_reg] <= pos_reg[vidx_reg] + 25'd1;
                    prod_reg <= mul_p;
                end
                ST_DVAL:
                begin
                    val_reg[vidx_reg] <= vq + delta;
                    step_reg[vidx_reg] <= 7'({1'b0, stc_reg}) + step_move(nib_reg[2:0]);
                end
                ST_DSCL:
                begin
                    scl_reg[vidx_reg] <= mul_p[23:0];
                    vidx_reg <= vidx_reg + 2'd1;
                    if (vidx_reg == 2'd3)
                    begin
                        acc_reg <= acc_reg - 18'(out_rate_reg);
                    end
                end
                ST_SUM:
                begin
                    cur_reg <= mix_clamped;
                end
                ST_IM1:
                begin
                    prod_reg <= mul_p;
                end
                ST_IM2:
                begin
                    neg_reg <= num < 0;
                    dvd_reg <= num_abs[31:0];
                    rem_reg <= '0;
                    dcnt_reg <= '0;
                end
                ST_DIV:
                begin
                    dcnt_reg <= dcnt_reg + 5'd1;
                    if (rem_sh >= {1'b0, out_rate_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, out_rate_reg};
                        dvd_reg <= {dvd_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        dvd_reg <= {dvd_reg[30:0], 1'b0};
                    end
                end
                ST_DONE:
                begin
                    res_sample_reg <= neg_reg ? -dvd_reg[15:0] : dvd_reg[15:0];
                    acc_reg <= acc_reg + 18'(dec_rate_reg);
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_sample_reg <= res_sample_reg;
                        out_status_reg <= {4'hf, flags_reg};
                    end
                end
                default:
                begin
                    vidx_reg <= vidx_reg;
                end
            endcase
        end
    end

    assign result.valid = out_valid_reg;
    assign result.sample = out_sample_reg;
    assign result.status = out_status_reg;
endmodule

### tb/tb_scoreboard.sv
`timescale 1ns / 1ps
// sample and status predictor with the queue of expected results
class adpcm_scoreboard;

    typedef struct {
        logic signed [15:0] sample;
        logic [7:0]         status;
    } mix_result_t;

    int unsigned step_tab[49] = '{
        16, 17, 19, 21, 23, 25, 28, 31, 34, 37,
        41, 45, 50, 55, 60, 66, 73, 80, 88, 97,
        107, 118, 130, 143, 157, 173, 190, 209, 230, 253,
        279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
        724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552};
    int move_tab[8] = '{-1, -1, -1, -1, 2, 4, 6, 8};
    int vol_tab[16] = '{80, 56, 40, 28, 20, 14, 10, 7, 5, 3, 2, 1, 1, 0, 0, 0};

    logic [7:0]  rom_bytes [262144];
    logic [24:0] pos [4];
    logic [24:0] stop_pos [4];
    int          level [4];
    int          step_idx [4];
    int          gain [4];
    int          scaled [4];
    int          mix_now;
    int          mix_old;
    logic [17:0] phase;
    logic [7:0]  flags;
    logic [7:0]  pend;
    int unsigned out_rate;
    int unsigned dec_rate;
    int unsigned rom_len;

    mix_result_t expected_mix[$];
    int          errors;
    int          checked;

    function new();
        for (int j = 0; j < 4; j++)
        begin
            pos[j] = 0; stop_pos[j] = 0; level[j] = 0;
            step_idx[j] = 0; gain[j] = 0; scaled[j] = 0;
        end
        mix_now = 0; mix_old = 0; phase = 0; flags = 8'hf0; pend = 0;
        out_rate = 0; dec_rate = 0; rom_len = 0;
        errors = 0; checked = 0;
    endfunction

    function void set_reg(fvap_pkg::cfg_idx_t idx, logic [18:0] val);
        case (idx)
            fvap_pkg::CFG_OUTPUT_RATE: out_rate = val[15:0];
            fvap_pkg::CFG_DECODE_RATE: dec_rate = val[15:0];
            fvap_pkg::CFG_ROM_LENGTH:  rom_len = val;
            default: ;
        endcase
    endfunction

    function int unsigned rd(int unsigned a);
        if (a >= rom_len || a >= 262144) return 0;
        return rom_bytes[a];
    endfunction

    function int wrap16(int x);
        logic signed [15:0] w;
        w = x[15:0];
        return w;
    endfunction

    function void decode_voice(int c);
        int unsigned a;
        int unsigned nib;
        int st;
        int mag;
        if (pos[c] >= stop_pos[c])
        begin
            level[c] = 0;
            flags[c] = 1'b0;
            return;
        end
        a = pos[c] >> 1;
        if (a >= rom_len)
        begin
            pos[c] = 0;
            return;
        end
        nib = rd(a);
        if (!pos[c][0])
            nib = nib >> 4;
        nib = nib & 15;
        pos[c] = pos[c] + 1;
        st = step_idx[c];
        if (st < 0) st = 0;
        if (st > 48) st = 48;
        mag = (step_tab[st] * (((nib & 7) << 1) + 1)) / 16;
        level[c] = wrap16((level[c] * 63) / 64);
        level[c] = wrap16(level[c] + ((nib & 8) ? -mag : mag));
        scaled[c] = level[c] * gain[c];
        step_idx[c] = st + move_tab[nib & 7];
    endfunction

    function void start_voice(logic [7:0] sel, logic [7:0] head);
        int c;
        int unsigned h;
        if (sel[4]) c = 0;
        else if (sel[5]) c = 1;
        else if (sel[6]) c = 2;
        else if (sel[7]) c = 3;
        else return;
        h = head[6:0] * 8;
        if (h + 6 > rom_len) return;
        pos[c] = ((rd(h) << 16) | (rd(h + 1) << 8) | rd(h + 2)) << 1;
        stop_pos[c] = ((rd(h + 3) << 16) | (rd(h + 4) << 8) | rd(h + 5)) << 1;
        level[c] = 0;
        step_idx[c] = 0;
        gain[c] = vol_tab[sel[3:0]];
        scaled[c] = 0;
        flags[c] = 1'b1;
    endfunction

    function void advance_mix();
        int sum;
        int q;
        mix_old = mix_now;
        while (phase >= out_rate)
        begin
            for (int j = 0; j < 4; j++)
                decode_voice(j);
            phase = phase - out_rate;
        end
        sum = scaled[0] + scaled[1] + scaled[2] + scaled[3];
        q = sum / 4;
        if (q * 4 != sum && sum < 0) q = q - 1;
        if (q > 32752) q = 32752;
        if (q < -32752) q = -32752;
        mix_now = q;
    endfunction

    function void note_request(fvap_pkg::op_t op, logic [17:0] addr, logic [7:0] rbyte,
                               logic [7:0] cbyte);
        mix_result_t r;
        longint v;
        case (op)
            fvap_pkg::OP_LOAD: rom_bytes[addr] = rbyte;
            fvap_pkg::OP_CMD:
            begin
                if (pend != 0)
                begin
                    start_voice(cbyte, pend);
                    pend = 0;
                end
                else if (cbyte[7])
                    pend = cbyte;
                else
                begin
                    if (cbyte[3]) begin stop_pos[0] = 0; flags[0] = 1'b0; end
                    if (cbyte[4]) begin stop_pos[1] = 0; flags[1] = 1'b0; end
                    if (cbyte[5]) begin stop_pos[2] = 0; flags[2] = 1'b0; end
                    if (cbyte[6]) begin stop_pos[3] = 0; flags[3] = 1'b0; end
                end
            end
            fvap_pkg::OP_STATUS:
            begin
                r.sample = 0;
                r.status = flags;
                expected_mix.push_back(r);
            end
            default:
            begin
                if (out_rate != 0)
                begin
                    if (phase >= out_rate)
                        advance_mix();
                    v = longint'(mix_old) * longint'(out_rate - phase)
                      + longint'(mix_now) * longint'(phase);
                    v = v / longint'(out_rate);
                    r.sample = v[15:0];
                    r.status = flags;
                    expected_mix.push_back(r);
                    phase = phase + dec_rate[17:0];
                end
            end
        endcase
    endfunction

    function void check_result(logic signed [15:0] sample, logic [7:0] status);
        mix_result_t e;
        checked++;
        if (expected_mix.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result: sample %0d status %02h", sample, status);
            return;
        end
        e = expected_mix.pop_front();
        if (e.sample !== sample || e.status !== status)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected sample %0d status %02h, got sample %0d status %02h",
                         e.sample, e.status, sample, status);
        end
    endfunction

endclass

### tb/tb.sv
`timescale 1ns / 1ps
// testbench top: rom fill, directed and random requests over several settings
module tb;
    import fvap_pkg::*;

    localparam int HDR_END = 128;
    localparam int DATA_END = 256;
    localparam int LIMIT = 20000000;
    localparam int HOLD_CYCLES = 3000;

    logic clk;
    logic rst_n;
    int   cycle;
    bit   quiet;
    int   hold_from;
    int   n_req;
    int   n_start;

    adpcm_scoreboard sb;

    fvap_in_if  cmd_if();
    fvap_out_if res_if();
    fvap_cfg_if cfg_if();

    four_voice_adpcm_player DUT (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd_if),
        .result(res_if),
        .cfg(cfg_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        cmd_if.valid = 0; cmd_if.operation = 0; cmd_if.rom_address = 0;
        cmd_if.rom_byte = 0; cmd_if.command_byte = 0;
        cfg_if.valid = 0; cfg_if.index = 0; cfg_if.data = 0;
        res_if.ready = 0;
        hold_from = -1;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.sample, res_if.status);
        if (hold_from >= 0 && cycle >= hold_from && cycle < hold_from + HOLD_CYCLES)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= quiet || ($urandom_range(99) >= 12);
    end

    task automatic send(op_t op, logic [17:0] addr, logic [7:0] rb, logic [7:0] cb);
        if (!quiet && $urandom_range(99) < 12)
        begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        cmd_if.valid <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.rom_address <= addr;
        cmd_if.rom_byte <= rb;
        cmd_if.command_byte <= cb;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
        sb.note_request(op, addr, rb, cb);
        n_req++;
    endtask

    task automatic drain();
        cmd_if.valid <= 1'b0;
        while (sb.expected_mix.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [18:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        sb.set_reg(idx, val);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_rates(logic [18:0] o, logic [18:0] d, logic [18:0] l);
        drain();
        write_reg(CFG_OUTPUT_RATE, o);
        write_reg(CFG_DECODE_RATE, d);
        write_reg(CFG_ROM_LENGTH, l);
    endtask

    // header bytes keep every sample read inside the filled area
    function automatic logic [7:0] header_byte(int k);
        case (k)
            2, 5: return 8'($urandom_range(DATA_END - 1));
            default: return 8'h00;
        endcase
    endfunction

    task automatic load_header_byte(int a);
        send(OP_LOAD, 18'(a), header_byte(a % 8), 8'($urandom));
    endtask

    task automatic start_voice(logic [6:0] hdr, logic [7:0] sel);
        send(OP_CMD, 18'($urandom), 8'($urandom), {1'b1, hdr});
        send(OP_CMD, 18'($urandom), 8'($urandom), sel);
        n_start++;
    endtask

    task automatic random_request();
        int r;
        int a;
        logic [7:0] cb;
        r = $urandom_range(99);
        if (r < 40)
            send(OP_TICK, 18'($urandom), 8'($urandom), 8'($urandom));
        else if (r < 48)
            send(OP_STATUS, 18'($urandom), 8'($urandom), 8'($urandom));
        else if (r < 68)
            start_voice(7'($urandom_range(HDR_END / 8 - 1)),
                        {4'(1 << $urandom_range(3)), 4'($urandom)});
        else if (r < 76)
            send(OP_CMD, 18'($urandom), 8'($urandom), {1'b0, 7'($urandom)});
        else if (r < 80)
        begin
            cb = 8'($urandom);
            if (cb[7])
                cb[6:4] = 3'd0;
            send(OP_CMD, 18'($urandom), 8'($urandom), cb);
        end
        else if (r < 86)
            load_header_byte($urandom_range(HDR_END - 1));
        else if (r < 94)
            send(OP_LOAD, 18'($urandom_range(DATA_END - 1, HDR_END)), 8'($urandom),
                 8'($urandom));
        else
        begin
            a = $urandom_range(262143, DATA_END);
            send(OP_LOAD, 18'(a), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic random_phase(logic [18:0] o, logic [18:0] d, logic [18:0] l, int count);
        set_rates(o, d, l);
        repeat (count) random_request();
    endtask

    initial
    begin
        logic [18:0] o;
        sb = new();
        cycle = 0;
        n_req = 0;
        n_start = 0;
        quiet = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill headers and sample area once
        quiet = 1;
        for (int a = 0; a < HDR_END; a++)
            load_header_byte(a);
        for (int a = HDR_END; a < DATA_END; a++)
            send(OP_LOAD, 18'(a), 8'($urandom), 8'h00);
        quiet = 0;

        // directed: ticks with output disabled and enabled, status, loads, starts and stops
        send(OP_TICK, 18'h3ffff, 8'hff, 8'hff);
        send(OP_STATUS, 18'h0, 8'h0, 8'h0);
        send(OP_LOAD, 18'h3ffff, 8'hff, 8'h00);
        send(OP_LOAD, 18'(DATA_END), 8'h00, 8'hff);
        set_rates(19'd100, 19'd250, 19'd262144);
        start_voice(7'd0, 8'h10);
        start_voice(7'd15, 8'h8f);
        start_voice(7'd5, 8'h2f);
        start_voice(7'd9, 8'h40);
        start_voice(7'd3, 8'h00);
        send(OP_STATUS, 18'h0, 8'h0, 8'h0);
        repeat (4) send(OP_TICK, 18'h0, 8'h0, 8'h0);
        send(OP_CMD, 18'h0, 8'h0, 8'h08);
        send(OP_CMD, 18'h0, 8'h0, 8'h78);
        send(OP_STATUS, 18'h0, 8'h0, 8'h0);
        send(OP_TICK, 18'h0, 8'h0, 8'h0);
        set_rates(19'd7, 19'd20, 19'd0);
        start_voice(7'd1, 8'h10);
        send(OP_TICK, 18'h0, 8'h0, 8'h0);
        send(OP_STATUS, 18'h0, 8'h0, 8'h0);

        random_phase(19'd65535, 19'd65535, 19'd262144, 50);
        random_phase(19'd1, 19'd0, 19'($urandom_range(262144)), 40);
        random_phase(19'd1, 19'd3, 19'd0, 30);
        random_phase(19'd0, 19'd123, 19'd1536, 30);
        quiet = 1;
        random_phase(19'd777, 19'd3000, 19'd1536, 50);
        quiet = 0;
        o = 19'($urandom_range(65535, 16));
        set_rates(o, 19'($urandom_range((o * 4 > 65535) ? 65535 : o * 4)),
                  19'($urandom_range(262144)));
        hold_from = cycle + 20;
        repeat (50) random_request();
        random_phase(19'd4, 19'd16, 19'd1000, 50);
        random_phase(19'd65535, 19'd0, 19'd700, 20);

        cmd_if.valid <= 1'b0;
        while (sb.expected_mix.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("covered %0d requests with %0d voice starts and %0d checked results",
                 n_req, n_start, sb.checked);
        $display("ten rate and rom length settings, one long result stall");
        if (sb.errors == 0 && sb.expected_mix.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
